[hw/rtl/blt_pkg.sv]
package blt_pkg;

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] TOKEN_MAX = 6'd32;

	localparam int MAX_RES = 3;
	localparam int RES_N_W = 2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NUL     = 8'h00;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] HELD_NONE    = 2'd0;
	localparam logic [1:0] HELD_LESS    = 2'd1;
	localparam logic [1:0] HELD_GREATER = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} item_t;

	// all results raised by one input word
	typedef struct packed {
		logic [RES_N_W-1:0]      n;
		item_t [MAX_RES-1:0]     items;
	} bundle_t;

endpackage

[hw/rtl/blt_front.sv]
module blt_front
	import blt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_in,
	input  logic       line_end,
	output logic       bundle_push,
	output bundle_t    bundle
);

	logic [CNT_W-1:0] count_q;
	logic             quote_q;
	logic [1:0]       held_q;
	logic             skip_q;

	logic [CNT_W-1:0] count_d;
	logic             quote_d;
	logic [1:0]       held_d;
	logic             skip_d;
	bundle_t          b;

	function automatic bundle_t put_item(bundle_t bi, logic kind, logic [7:0] ch);
		bundle_t bo;
		bo = bi;
		if (bi.n != RES_N_W'(MAX_RES)) begin
			bo.items[bi.n].kind = kind;
			bo.items[bi.n].ch   = ch;
			bo.n                = bi.n + RES_N_W'(1);
		end
		return bo;
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
		       (c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == CH_UNDER;
	endfunction

	always_comb begin
		logic pair;
		logic done;
		count_d = count_q;
		quote_d = quote_q;
		held_d  = held_q;
		skip_d  = skip_q;
		b       = '0;
		pair    = 1'b0;
		done    = 1'b0;

		if (!skip_q && char_in != CH_NUL) begin
			if (held_d != HELD_NONE) begin
				pair = (held_d == HELD_LESS && (char_in == CH_EQUAL || char_in == CH_GREATER)) ||
				       (held_d == HELD_GREATER && char_in == CH_EQUAL);
				held_d = HELD_NONE;
				if (pair) begin
					b = put_item(b, KIND_CHAR, char_in);
					done = 1'b1;
				end
				b = put_item(b, KIND_END, CH_NUL);
				count_d = '0;
			end

			if (!done) begin
				if (char_in == CH_DQUOTE && quote_d) begin
					b = put_item(b, KIND_CHAR, char_in);
					b = put_item(b, KIND_END, CH_NUL);
					count_d = '0;
					quote_d = 1'b0;
				end else if (char_in == CH_DQUOTE || is_word(char_in) || quote_d) begin
					if (char_in == CH_DQUOTE)
						quote_d = 1'b1;
					b = put_item(b, KIND_CHAR, char_in);
					count_d = count_d + CNT_W'(1);
					if (count_d >= TOKEN_MAX) begin
						b = put_item(b, KIND_END, CH_NUL);
						count_d = '0;
						quote_d = 1'b0;
					end
				end else if (char_in == CH_SPACE || char_in == CH_TAB) begin
					if (count_d != '0) begin
						b = put_item(b, KIND_END, CH_NUL);
						count_d = '0;
					end
				end else if (char_in == CH_APOS) begin
					if (count_d != '0) begin
						b = put_item(b, KIND_END, CH_NUL);
						count_d = '0;
					end
					skip_d = 1'b1;
				end else begin
					if (count_d != '0) begin
						b = put_item(b, KIND_END, CH_NUL);
						count_d = '0;
					end
					b = put_item(b, KIND_CHAR, char_in);
					if (char_in == CH_LESS) begin
						held_d  = HELD_LESS;
						count_d = CNT_W'(1);
					end else if (char_in == CH_GREATER) begin
						held_d  = HELD_GREATER;
						count_d = CNT_W'(1);
					end else begin
						b = put_item(b, KIND_END, CH_NUL);
						count_d = '0;
					end
				end
			end
		end

		if (line_end) begin
			if (count_d != '0 || held_d != HELD_NONE || quote_d)
				b = put_item(b, KIND_END, CH_NUL);
			count_d = '0;
			quote_d = 1'b0;
			held_d  = HELD_NONE;
			skip_d  = 1'b0;
		end
	end

	assign bundle      = b;
	assign bundle_push = accept && (b.n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			quote_q <= 1'b0;
			held_q  <= HELD_NONE;
			skip_q  <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			quote_q <= quote_d;
			held_q  <= held_d;
			skip_q  <= skip_d;
		end
	end

endmodule

[hw/rtl/blt_queue.sv]
module blt_queue
	import blt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	input  logic    rd_en,
	output bundle_t rd_data,
	output logic    full,
	output logic    not_empty
);

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/blt_back.sv]
module blt_back
	import blt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  bundle_t    head,
	input  logic       head_valid,
	input  logic       pop,
	output logic       head_done,
	output logic       empty,
	output logic       item_kind,
	output logic [7:0] token_char,
	output logic       run_last
);

	logic [RES_N_W-1:0] idx_q;
	logic               last;
	logic               take;

	assign empty      = !head_valid;
	assign take       = pop && head_valid;
	assign last       = (idx_q == head.n - RES_N_W'(1));
	assign item_kind  = head.items[idx_q].kind;
	assign token_char = head.items[idx_q].ch;
	assign run_last   = last;
	assign head_done  = take && last;

	// walks through the head bundle one word per pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (take) begin
			if (last)
				idx_q <= '0;
			else
				idx_q <= idx_q + RES_N_W'(1);
		end
	end

endmodule

[hw/rtl/basic_line_tokenizer.sv]
// Line tokenizer: one byte per pushed word, up to three result words per byte
// (token characters and end-of-token marks, run_last on the final one). A byte
// is taken every cycle while the four-bundle queue between the classifier and
// the output serialiser has room; results leave at one word per cycle while pop
// is high, and every result a byte raises takes a pop of its own. Bytes that
// raise no result never enter the queue.
module basic_line_tokenizer
	import blt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       line_end,
	output logic       empty,
	input  logic       pop,
	output logic       item_kind,
	output logic [7:0] token_char,
	output logic       run_last
);

	logic    accept;
	logic    bundle_push;
	bundle_t bundle;
	bundle_t head;
	logic    head_valid;
	logic    head_done;

	assign accept = push && !full;

	blt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_in     (char_in),
		.line_end    (line_end),
		.bundle_push (bundle_push),
		.bundle      (bundle)
	);

	blt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (bundle_push),
		.wr_data   (bundle),
		.rd_en     (head_done),
		.rd_data   (head),
		.full      (full),
		.not_empty (head_valid)
	);

	blt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.head_done  (head_done),
		.empty      (empty),
		.item_kind  (item_kind),
		.token_char (token_char),
		.run_last   (run_last)
	);

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import blt_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BYTES   = 210;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		logic       last;
	} word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       line_end = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       item_kind;
	logic [7:0] token_char;
	logic       run_last;

	basic_line_tokenizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_in    (char_in),
		.line_end   (line_end),
		.empty      (empty),
		.pop        (pop),
		.item_kind  (item_kind),
		.token_char (token_char),
		.run_last   (run_last)
	);

	// tokenizer state as predicted
	logic [CNT_W-1:0] tok_len = '0;
	logic             in_quote = 1'b0;
	logic [1:0]       pending_sym = HELD_NONE;
	logic             skip_line = 1'b0;

	word_t      byte_words[$];
	word_t      expected_words[$];
	logic [7:0] line_bytes[$];

	string word_set = "ABCXYZabcmxyz0159._";
	string sym_set  = "<>=<>=+-*/(),;:#";

	int  bytes_sent = 0;
	int  lines_sent = 0;
	int  words_checked = 0;
	int  mismatches = 0;
	int  limit_cuts = 0;
	int  full_cycles = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function void emit_word(input logic kind, input logic [7:0] ch);
		word_t w;
		if (byte_words.size() < MAX_RES) begin
			w.kind = kind;
			w.ch = ch;
			w.last = 1'b0;
			byte_words.push_back(w);
		end
	endfunction

	function void end_token();
		emit_word(KIND_END, CH_NUL);
		tok_len = '0;
	endfunction

	function void take_char(input logic [7:0] c);
		emit_word(KIND_CHAR, c);
		tok_len = tok_len + 1'b1;
		if (tok_len >= TOKEN_MAX) begin
			end_token();
			in_quote = 1'b0;
			limit_cuts++;
		end
	endfunction

	// works out the words one accepted byte raises and queues them
	function void tokenize_byte(input logic [7:0] c, input logic le);
		logic  paired;
		word_t w;
		paired = 1'b0;
		byte_words.delete();
		if (!skip_line && c != CH_NUL) begin
			if (pending_sym != HELD_NONE) begin
				paired = (pending_sym == HELD_LESS && (c == CH_EQUAL || c == CH_GREATER)) ||
					(pending_sym == HELD_GREATER && c == CH_EQUAL);
				pending_sym = HELD_NONE;
				if (paired)
					emit_word(KIND_CHAR, c);
				end_token();
			end
			if (!paired) begin
				if (c == CH_DQUOTE) begin
					if (in_quote) begin
						emit_word(KIND_CHAR, c);
						end_token();
						in_quote = 1'b0;
					end else begin
						in_quote = 1'b1;
						take_char(c);
					end
				end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
					(c >= "0" && c <= "9") || c == CH_DOT || c == CH_UNDER || in_quote) begin
					take_char(c);
				end else if (c == CH_SPACE || c == CH_TAB) begin
					if (tok_len != 0)
						end_token();
				end else if (c == CH_APOS) begin
					if (tok_len != 0)
						end_token();
					skip_line = 1'b1;
				end else begin
					if (tok_len != 0)
						end_token();
					emit_word(KIND_CHAR, c);
					// < and > stay open as a one-char token until the next byte
					if (c == CH_LESS) begin
						pending_sym = HELD_LESS;
						tok_len = CNT_W'(1);
					end else if (c == CH_GREATER) begin
						pending_sym = HELD_GREATER;
						tok_len = CNT_W'(1);
					end else begin
						end_token();
					end
				end
			end
		end
		if (le) begin
			if (tok_len != 0 || pending_sym != HELD_NONE || in_quote)
				emit_word(KIND_END, CH_NUL);
			tok_len = '0;
			in_quote = 1'b0;
			pending_sym = HELD_NONE;
			skip_line = 1'b0;
		end
		for (int i = 0; i < byte_words.size(); i++) begin
			w = byte_words[i];
			w.last = (i == byte_words.size() - 1);
			expected_words.push_back(w);
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic le);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(0, 10);
				repeat (gap) begin
					@(negedge clk);
					push <= 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		char_in <= c;
		line_end <= le;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tokenize_byte(c, le);
		bytes_sent++;
		if (le)
			lines_sent++;
	endtask

	task automatic push_line();
		for (int i = 0; i < line_bytes.size(); i++)
			send_byte(line_bytes[i], i == line_bytes.size() - 1);
		line_bytes.delete();
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	task automatic test_directed_lines();
		load_text("x<>y");
		push_line();
		load_text(">=<<a");
		push_line();
		// quote joins a word, then a string left open at line end
		load_text("a\"\t\" \"");
		push_line();
		load_text("+'\"z");
		push_line();
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NUL, 1'b1);
		send_byte(CH_LESS, 1'b1);
	endtask

	// receiver holds off while bytes keep coming, so the block fills and raises full
	task automatic test_backpressure();
		gaps_on = 1'b0;
		@(negedge clk);
		push <= 1'b0;
		hold_req = 1'b1;
		repeat (2) begin
			load_text("A+B*C-D/E=F");
			push_line();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_random_lines();
		int start;
		int kind;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 6)) begin
				kind = $urandom_range(0, 39);
				if (kind < 14) begin
					repeat ($urandom_range(1, 6))
						line_bytes.push_back(word_set[$urandom_range(0, word_set.len() - 1)]);
				end else if (kind < 18) begin
					line_bytes.push_back(CH_DQUOTE);
					repeat ($urandom_range(0, 5))
						line_bytes.push_back(8'($urandom_range(1, 255)));
					if ($urandom_range(0, 3) != 0)
						line_bytes.push_back(CH_DQUOTE);
				end else if (kind < 26) begin
					line_bytes.push_back(sym_set[$urandom_range(0, sym_set.len() - 1)]);
					if ($urandom_range(0, 1))
						line_bytes.push_back(sym_set[$urandom_range(0, sym_set.len() - 1)]);
				end else if (kind < 31) begin
					line_bytes.push_back(8'($urandom_range(1, 255)));
				end else if (kind < 33) begin
					line_bytes.push_back(CH_APOS);
					repeat ($urandom_range(0, 4))
						line_bytes.push_back(8'($urandom_range(1, 255)));
				end else if (kind == 33) begin
					// long word or string around the length limit
					if ($urandom_range(0, 1))
						line_bytes.push_back(CH_DQUOTE);
					repeat ($urandom_range(TOKEN_MAX - 2, TOKEN_MAX + 2))
						line_bytes.push_back(word_set[$urandom_range(0, word_set.len() - 1)]);
				end else begin
					line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				end
				if ($urandom_range(0, 1))
					line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end
			push_line();
		end
		gaps_on = 1'b1;
	endtask

	always @(negedge clk) begin : receiver
		int          rx_phase;
		int          hold_left;
		logic [15:0] rx_pattern;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (rx_phase == 0) begin
			rx_phase = 64;
			rx_pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
		end
		rx_phase--;
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= rx_pattern[0];
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		end
	end

	always @(posedge clk) begin : result_check
		word_t want;
		if (arst_n && pop && !empty) begin
			words_checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word kind %0d char %02h last %0d",
						$time, item_kind, token_char, run_last);
			end else begin
				want = expected_words.pop_front();
				if (item_kind !== want.kind || token_char !== want.ch ||
					run_last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
							$time, want.kind, want.ch, want.last,
							item_kind, token_char, run_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (push && full)
			full_cycles++;
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", idle_cycles);
				$display("basic_line_tokenizer verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_lines();
		test_backpressure();
		test_random_lines();
		@(negedge clk);
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes over %0d lines pushed, %0d result words compared",
			bytes_sent, lines_sent, words_checked);
		$display("%0d tokens cut at the length limit, input stalled by full for %0d cycles",
			limit_cuts, full_cycles);
		if (mismatches == 0) begin
			$display("basic_line_tokenizer verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("basic_line_tokenizer verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/blt_pkg.sv
hw/rtl/blt_front.sv
hw/rtl/blt_queue.sv
hw/rtl/blt_back.sv
hw/rtl/basic_line_tokenizer.sv
tb/tb_top.sv
